/* rtl/qpw_pkg.sv */
// Shared constants, types and codes of the quadratic point warp.
package qpw_pkg;

  // Fixed-point formats
  localparam int COORD_FRAC_BITS = 16;
  localparam int COEF_FRAC_BITS  = 32;
  localparam int COORD_W         = 32;
  localparam int COEF_W          = 48;
  localparam int TERM_W          = 2 * COORD_W;
  localparam int LO_W            = 32;   // low split of coefficients and terms
  localparam int COEF_HI_W       = COEF_W - LO_W;

  // Exact row sum; the largest row sum stays well below 2**114
  localparam int ACC_W     = 120;
  localparam int RND_SHIFT = COEF_FRAC_BITS + COORD_FRAC_BITS;

  // Coefficient store layout
  localparam int STORE_DEPTH = 30;
  localparam int IDX_W       = 5;
  localparam int NUM_ROWS    = 3;
  localparam int NUM_QUAD    = 6;
  localparam int NUM_LIN     = 3;
  localparam int LIN_BASE    = 18;
  localparam int TRN_BASE    = 27;

  // Register stages inside one row datapath
  localparam int ROW_STAGES = 4;

  // Codes
  localparam logic       ACT_LOAD  = 1'b0;
  localparam logic       ACT_MAP   = 1'b1;
  localparam logic [1:0] DIM_2D    = 2'd2;
  localparam logic [1:0] DIM_RESET = 2'd3;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [COEF_W-1:0]  coef_t;
  typedef logic signed [TERM_W-1:0]  term_t;
  typedef logic signed [ACC_W-1:0]   acc_t;

  localparam coef_t COEF_ONE   = coef_t'(1) << COEF_FRAC_BITS;
  localparam acc_t  ROUND_HALF = acc_t'(1) << (RND_SHIFT - 1);

  // Quadratic terms and coordinates of one point, ordered per dimension
  typedef struct packed {
    term_t  [NUM_QUAD-1:0] h;
    coord_t [NUM_LIN-1:0]  p;
  } point_terms_t;

  // Coefficients that one output row uses
  typedef struct packed {
    coef_t [NUM_QUAD-1:0] quad;
    coef_t [NUM_LIN-1:0]  lin;
    coef_t                trn;
  } row_coef_t;

endpackage

/* rtl/qpw_coef_store.sv */
// Coefficient store: thirty registers that reset to the identity warp.
module qpw_coef_store import qpw_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             we_i,
  input  logic [IDX_W-1:0] idx_i,
  input  coef_t            value_i,
  output coef_t            coef_o [STORE_DEPTH]
);

  coef_t store_q [STORE_DEPTH];

  // Identity on the linear diagonal; slots past the end are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < STORE_DEPTH; i++) begin
        store_q[i] <= (i == LIN_BASE || i == LIN_BASE + 4 || i == LIN_BASE + 8) ?
                      COEF_ONE : coef_t'(0);
      end
    end else if (we_i && (idx_i < IDX_W'(STORE_DEPTH))) begin
      store_q[idx_i] <= value_i;
    end
  end

  assign coef_o = store_q;

endmodule

/* rtl/qpw_quad_terms.sv */
// Square and cross products of the point, arranged for 2D or 3D.
module qpw_quad_terms import qpw_pkg::*; (
  input  logic         clk_i,
  input  logic         is3d_i,
  input  coord_t       x_i,
  input  coord_t       y_i,
  input  coord_t       z_i,
  output point_terms_t terms_o
);

  point_terms_t terms_d, terms_q;
  coord_t       a2, b2, a3, a4, a5, p2;

  // 3D: xx yy zz xy yz xz; 2D: xx yy xy, rest zero
  always_comb begin
    a2 = is3d_i ? z_i : x_i;
    b2 = is3d_i ? z_i : y_i;
    a3 = is3d_i ? x_i : coord_t'(0);
    a4 = is3d_i ? y_i : coord_t'(0);
    a5 = is3d_i ? x_i : coord_t'(0);
    p2 = is3d_i ? z_i : coord_t'(0);
    terms_d.h[0] = x_i * x_i;
    terms_d.h[1] = y_i * y_i;
    terms_d.h[2] = a2 * b2;
    terms_d.h[3] = a3 * y_i;
    terms_d.h[4] = a4 * z_i;
    terms_d.h[5] = a5 * z_i;
    terms_d.p[0] = x_i;
    terms_d.p[1] = y_i;
    terms_d.p[2] = p2;
  end

  always_ff @(posedge clk_i) begin
    terms_q <= terms_d;
  end

  assign terms_o = terms_q;

endmodule

/* rtl/qpw_row.sv */
// One output row: partial products, term sums, rounding and saturation.
module qpw_row import qpw_pkg::*; (
  input  logic         clk_i,
  input  point_terms_t terms_i,
  input  row_coef_t    coef_i,
  output coord_t       coord_o,
  output logic         clip_o
);

  // Stage 1: 32-bit partial products
  logic        [TERM_W-1:0]         qll_d [NUM_QUAD];
  logic        [TERM_W-1:0]         qll_q [NUM_QUAD];
  logic signed [TERM_W:0]           qlh_d [NUM_QUAD];
  logic signed [TERM_W:0]           qlh_q [NUM_QUAD];
  logic signed [COEF_HI_W+LO_W:0]   qhl_d [NUM_QUAD];
  logic signed [COEF_HI_W+LO_W:0]   qhl_q [NUM_QUAD];
  logic signed [COEF_HI_W+LO_W-1:0] qhh_d [NUM_QUAD];
  logic signed [COEF_HI_W+LO_W-1:0] qhh_q [NUM_QUAD];
  logic signed [LO_W+COORD_W:0]     llo_d [NUM_LIN];
  logic signed [LO_W+COORD_W:0]     llo_q [NUM_LIN];
  logic signed [COEF_HI_W+COORD_W-1:0] lhi_d [NUM_LIN];
  logic signed [COEF_HI_W+COORD_W-1:0] lhi_q [NUM_LIN];
  coef_t trn_q;

  always_comb begin
    for (int k = 0; k < NUM_QUAD; k++) begin
      qll_d[k] = coef_i.quad[k][LO_W-1:0] * terms_i.h[k][LO_W-1:0];
      qlh_d[k] = $signed({1'b0, coef_i.quad[k][LO_W-1:0]}) *
                 $signed(terms_i.h[k][TERM_W-1:LO_W]);
      qhl_d[k] = $signed(coef_i.quad[k][COEF_W-1:LO_W]) *
                 $signed({1'b0, terms_i.h[k][LO_W-1:0]});
      qhh_d[k] = $signed(coef_i.quad[k][COEF_W-1:LO_W]) *
                 $signed(terms_i.h[k][TERM_W-1:LO_W]);
    end
    for (int k = 0; k < NUM_LIN; k++) begin
      llo_d[k] = $signed({1'b0, coef_i.lin[k][LO_W-1:0]}) * $signed(terms_i.p[k]);
      lhi_d[k] = $signed(coef_i.lin[k][COEF_W-1:LO_W]) * $signed(terms_i.p[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    qll_q <= qll_d;
    qlh_q <= qlh_d;
    qhl_q <= qhl_d;
    qhh_q <= qhh_d;
    llo_q <= llo_d;
    lhi_q <= lhi_d;
    trn_q <= $signed(coef_i.trn);
  end

  // Stage 2: full products aligned to the sum's fraction point
  acc_t qterm_d [NUM_QUAD];
  acc_t qterm_q [NUM_QUAD];
  acc_t lterm_d [NUM_LIN];
  acc_t lterm_q [NUM_LIN];
  acc_t tterm_q;

  always_comb begin
    for (int k = 0; k < NUM_QUAD; k++) begin
      qterm_d[k] = (acc_t'(qhh_q[k]) <<< (2 * LO_W)) +
                   ((acc_t'(qlh_q[k]) + acc_t'(qhl_q[k])) <<< LO_W) +
                   acc_t'(qll_q[k]);
    end
    for (int k = 0; k < NUM_LIN; k++) begin
      lterm_d[k] = ((acc_t'(lhi_q[k]) <<< LO_W) + acc_t'(llo_q[k])) <<< COORD_FRAC_BITS;
    end
  end

  always_ff @(posedge clk_i) begin
    qterm_q <= qterm_d;
    lterm_q <= lterm_d;
    tterm_q <= acc_t'(trn_q) <<< (2 * COORD_FRAC_BITS);
  end

  // Stage 3: three group sums
  acc_t grp_a_q, grp_b_q, grp_c_q;

  always_ff @(posedge clk_i) begin
    grp_a_q <= qterm_q[0] + qterm_q[1] + qterm_q[2] + tterm_q;
    grp_b_q <= qterm_q[3] + qterm_q[4] + qterm_q[5];
    grp_c_q <= lterm_q[0] + lterm_q[1] + lterm_q[2];
  end

  // Stage 4: round half up, then clip to the coordinate range
  acc_t                      total;
  acc_t                      rounded;
  logic [ACC_W-COORD_W:0]    upper;
  logic                      fits;
  coord_t                    coord_d, coord_q;
  logic                      clip_d, clip_q;

  always_comb begin
    total   = grp_a_q + grp_b_q + grp_c_q + ROUND_HALF;
    rounded = total >>> RND_SHIFT;
    upper   = rounded[ACC_W-1:COORD_W-1];
    fits    = (&upper) | ~(|upper);
    clip_d  = ~fits;
    if (fits) begin
      coord_d = rounded[COORD_W-1:0];
    end else if (rounded[ACC_W-1]) begin
      coord_d = {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      coord_d = {1'b0, {(COORD_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i) begin
    coord_q <= coord_d;
    clip_q  <= clip_d;
  end

  assign coord_o = coord_q;
  assign clip_o  = clip_q;

endmodule

/* rtl/quadratic_point_warp_top.sv */
// Top level of the quadratic point warp: input stage, store, rows, result.
//
// One beat is taken in every cycle and busy never rises. A map beat gives its
// strobe on done_o once through the datapath and a load beat gives none;
// a load is seen by every map accepted after it, also in the very next cycle.
// The datapath holds six registers: input register, square products, 32-bit
// partial products against the coefficient store, product alignment, group
// sums, and round and clip. Results are shown for one cycle only and cannot
// be held off, so the receiver must take each strobe. Write the dimension
// register only while no map beat is in flight.
module quadratic_point_warp_top import qpw_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  logic             action_i,
  input  logic [IDX_W-1:0] coef_index_i,
  input  coef_t            coef_value_i,
  input  coord_t           in_x_i,
  input  coord_t           in_y_i,
  input  coord_t           in_z_i,
  input  logic             dimension_we_i,
  input  logic [1:0]       dimension_i,
  output logic             done_o,
  output coord_t           out_x_o,
  output coord_t           out_y_o,
  output coord_t           out_z_o,
  output logic             saturated_o
);

  logic accept;
  logic is3d;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  // Dimension register
  logic [1:0] dimension_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dimension_q <= DIM_RESET;
    end else if (dimension_we_i) begin
      dimension_q <= dimension_i;
    end
  end

  assign is3d = (dimension_q != DIM_2D);

  // Beat payload through the first two stages
  logic             s1_act_q, s2_act_q;
  logic [IDX_W-1:0] s1_idx_q, s2_idx_q;
  coef_t            s1_val_q, s2_val_q;
  coord_t           s1_x_q, s1_y_q, s1_z_q;

  // Valid bits of the input and product stages, and the row pipeline
  logic                  s1_vld_q, s2_vld_q;
  logic [ROW_STAGES-1:0] map_pipe_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q   <= 1'b0;
      s2_vld_q   <= 1'b0;
      map_pipe_q <= '0;
    end else begin
      s1_vld_q   <= accept;
      s2_vld_q   <= s1_vld_q;
      map_pipe_q <= {map_pipe_q[ROW_STAGES-2:0], s2_vld_q & (s2_act_q == ACT_MAP)};
    end
  end

  always_ff @(posedge clk_i) begin
    s1_act_q <= action_i;
    s1_idx_q <= coef_index_i;
    s1_val_q <= coef_value_i;
    s1_x_q   <= in_x_i;
    s1_y_q   <= in_y_i;
    s1_z_q   <= in_z_i;
    s2_act_q <= s1_act_q;
    s2_idx_q <= s1_idx_q;
    s2_val_q <= s1_val_q;
  end

  // Square and cross products
  point_terms_t s2_terms;

  qpw_quad_terms u_terms (
    .clk_i   (clk_i),
    .is3d_i  (is3d),
    .x_i     (s1_x_q),
    .y_i     (s1_y_q),
    .z_i     (s1_z_q),
    .terms_o (s2_terms)
  );

  // Loads write the store in the stage where maps read it
  coef_t coef [STORE_DEPTH];

  qpw_coef_store u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (s2_vld_q & (s2_act_q == ACT_LOAD)),
    .idx_i   (s2_idx_q),
    .value_i (s2_val_q),
    .coef_o  (coef)
  );

  // Row datapaths
  coord_t              row_coord [NUM_ROWS];
  logic [NUM_ROWS-1:0] row_clip;

  for (genvar r = 0; r < NUM_ROWS; r++) begin : g_row
    row_coef_t rc;

    always_comb begin
      for (int k = 0; k < NUM_QUAD; k++) begin
        rc.quad[k] = coef[r * NUM_QUAD + k];
      end
      for (int k = 0; k < NUM_LIN; k++) begin
        rc.lin[k] = coef[LIN_BASE + r * NUM_LIN + k];
      end
      rc.trn = coef[TRN_BASE + r];
    end

    qpw_row u_row (
      .clk_i   (clk_i),
      .terms_i (s2_terms),
      .coef_i  (rc),
      .coord_o (row_coord[r]),
      .clip_o  (row_clip[r])
    );
  end

  // Result beat; z row is dropped in 2D
  assign done_o      = map_pipe_q[ROW_STAGES-1];
  assign out_x_o     = row_coord[0];
  assign out_y_o     = row_coord[1];
  assign out_z_o     = is3d ? row_coord[2] : coord_t'(0);
  assign saturated_o = row_clip[0] | row_clip[1] | (row_clip[2] & is3d);

endmodule

/* tb/sv/tb.sv */
// Testbench for quadratic_point_warp_top: random and directed beats checked against a predictor.
module tb;
  import qpw_pkg::*;

  typedef logic signed [127:0] wide_t;

  // One input beat and one mapped point
  typedef struct {
    logic             action;
    logic [IDX_W-1:0] index;
    coef_t            value;
    coord_t           x;
    coord_t           y;
    coord_t           z;
  } warp_beat_t;

  typedef struct {
    coord_t x;
    coord_t y;
    coord_t z;
    logic   sat;
  } mapped_point_t;

  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned STALL_LIMIT   = 1000;
  localparam int unsigned PHASE_BEATS   = 175;
  localparam int unsigned LOAD_PCT      = 25;

  // Scoreboard: keeps its own coefficient store and predicts every map
  class warp_scoreboard;
    coef_t           coef_store[STORE_DEPTH];
    logic [1:0]      dim_code;
    wide_t           pt[NUM_LIN];
    wide_t           sq[NUM_QUAD];
    logic            clip_any;
    mapped_point_t   pending[$];
    int unsigned     mismatches;
    int unsigned     maps_seen;
    int unsigned     loads_seen;
    int unsigned     clipped_seen;

    function new();
      for (int i = 0; i < STORE_DEPTH; i++) coef_store[i] = '0;
      for (int r = 0; r < NUM_LIN; r++) coef_store[LIN_BASE + r * (NUM_LIN + 1)] = COEF_ONE;
      dim_code     = DIM_RESET;
      mismatches   = 0;
      maps_seen    = 0;
      loads_seen   = 0;
      clipped_seen = 0;
    endfunction

    function void set_dimension(logic [1:0] d);
      dim_code = d;
    endfunction

    // Exact row sum, rounded half up, then clipped to the coordinate range
    function coord_t row_value(int r, int n, int nh);
      wide_t acc;
      wide_t c;
      wide_t v;
      wide_t half;
      c    = coef_store[TRN_BASE + r];
      acc  = c <<< (2 * COORD_FRAC_BITS);
      half = wide_t'(1) <<< (COEF_FRAC_BITS + COORD_FRAC_BITS - 1);
      for (int k = 0; k < nh; k++) begin
        c   = coef_store[r * NUM_QUAD + k];
        acc = acc + c * sq[k];
      end
      for (int k = 0; k < n; k++) begin
        c   = coef_store[LIN_BASE + r * NUM_LIN + k];
        acc = acc + ((c * pt[k]) <<< COORD_FRAC_BITS);
      end
      v = (acc + half) >>> (COEF_FRAC_BITS + COORD_FRAC_BITS);
      if (v > 128'sh7FFF_FFFF) begin
        clip_any = 1'b1;
        return 32'sh7FFF_FFFF;
      end
      if (v < -128'sh8000_0000) begin
        clip_any = 1'b1;
        return 32'sh8000_0000;
      end
      return coord_t'(v[31:0]);
    endfunction

    // Accepted input beat: write the store or queue the mapped point
    function void note_beat(warp_beat_t b);
      mapped_point_t m;
      if (b.action == ACT_LOAD) begin
        loads_seen++;
        if (b.index < STORE_DEPTH) coef_store[b.index] = b.value;
        return;
      end
      maps_seen++;
      pt[0] = b.x;
      pt[1] = b.y;
      pt[2] = b.z;
      clip_any = 1'b0;
      m.z = '0;
      if (dim_code == DIM_2D) begin
        sq[0] = pt[0] * pt[0];
        sq[1] = pt[1] * pt[1];
        sq[2] = pt[0] * pt[1];
        m.x = row_value(0, 2, 3);
        m.y = row_value(1, 2, 3);
      end else begin
        sq[0] = pt[0] * pt[0];
        sq[1] = pt[1] * pt[1];
        sq[2] = pt[2] * pt[2];
        sq[3] = pt[0] * pt[1];
        sq[4] = pt[1] * pt[2];
        sq[5] = pt[0] * pt[2];
        m.x = row_value(0, 3, 6);
        m.y = row_value(1, 3, 6);
        m.z = row_value(2, 3, 6);
      end
      m.sat = clip_any;
      if (clip_any) clipped_seen++;
      pending.push_back(m);
    endfunction

    // Result beat: compare with the oldest predicted point
    function void check_point(mapped_point_t got);
      mapped_point_t exp_pt;
      if (pending.size() == 0) begin
        $error("result beat with no map pending");
        mismatches++;
        return;
      end
      exp_pt = pending.pop_front();
      if (got.x !== exp_pt.x) begin
        $error("out_x: expected %0d, got %0d", exp_pt.x, got.x);
        mismatches++;
      end
      if (got.y !== exp_pt.y) begin
        $error("out_y: expected %0d, got %0d", exp_pt.y, got.y);
        mismatches++;
      end
      if (got.z !== exp_pt.z) begin
        $error("out_z: expected %0d, got %0d", exp_pt.z, got.z);
        mismatches++;
      end
      if (got.sat !== exp_pt.sat) begin
        $error("saturated: expected %0b, got %0b", exp_pt.sat, got.sat);
        mismatches++;
      end
    endfunction
  endclass

  logic             clk_i          = 1'b0;
  logic             rst_ni         = 1'b0;
  logic             start          = 1'b0;
  logic             busy;
  logic             action_i       = ACT_MAP;
  logic [IDX_W-1:0] coef_index_i   = '0;
  coef_t            coef_value_i   = '0;
  coord_t           in_x_i         = '0;
  coord_t           in_y_i         = '0;
  coord_t           in_z_i         = '0;
  logic             dimension_we_i = 1'b0;
  logic [1:0]       dimension_i    = DIM_RESET;
  logic             done_o;
  coord_t           out_x_o;
  coord_t           out_y_o;
  coord_t           out_z_o;
  logic             saturated_o;

  warp_scoreboard sb = new();
  int unsigned    stall_cycles = 0;

  quadratic_point_warp_top DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .action_i       (action_i),
    .coef_index_i   (coef_index_i),
    .coef_value_i   (coef_value_i),
    .in_x_i         (in_x_i),
    .in_y_i         (in_y_i),
    .in_z_i         (in_z_i),
    .dimension_we_i (dimension_we_i),
    .dimension_i    (dimension_i),
    .done_o         (done_o),
    .out_x_o        (out_x_o),
    .out_y_o        (out_y_o),
    .out_z_o        (out_z_o),
    .saturated_o    (saturated_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Monitor: results are checked before the beat of the same edge is noted
  always @(posedge clk_i) begin : monitor
    warp_beat_t    beat;
    mapped_point_t got;
    if (rst_ni) begin
      if (done_o) begin
        got.x   = out_x_o;
        got.y   = out_y_o;
        got.z   = out_z_o;
        got.sat = saturated_o;
        sb.check_point(got);
      end
      if (start && !busy) begin
        beat.action = action_i;
        beat.index  = coef_index_i;
        beat.value  = coef_value_i;
        beat.x      = in_x_i;
        beat.y      = in_y_i;
        beat.z      = in_z_i;
        sb.note_beat(beat);
      end
      if (dimension_we_i) sb.set_dimension(dimension_i);
    end
  end

  // Watchdog on cycles with no beat in either direction
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout: no beat for %0d cycles", STALL_LIMIT);
      $display("FAIL");
      $finish;
    end
  end

  // Random coordinate: mostly sign-extended from a random width
  function automatic coord_t rand_coord();
    logic [31:0]  r;
    int unsigned  sh;
    coord_t       v;
    r = $urandom;
    case ($urandom_range(0, 9))
      0: v = r;
      1: begin
        case ($urandom_range(0, 4))
          0: v = 32'sh7FFF_FFFF;
          1: v = 32'sh8000_0000;
          2: v = '0;
          3: v = -32'sd1;
          default: v = 32'sd1;
        endcase
      end
      default: begin
        sh = 32 - $urandom_range(1, 32);
        v  = r << sh;
        v  = v >>> sh;
      end
    endcase
    return v;
  endfunction

  // Random coefficient; quadratic slots lean toward small magnitudes
  function automatic coef_t rand_coef(int unsigned slot);
    logic [63:0] r;
    int unsigned sh;
    coef_t       v;
    r = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0: v = r[47:0];
      1: begin
        case ($urandom_range(0, 4))
          0: v = {1'b0, {(COEF_W-1){1'b1}}};
          1: v = {1'b1, {(COEF_W-1){1'b0}}};
          2: v = COEF_ONE;
          3: v = -COEF_ONE;
          default: v = '0;
        endcase
      end
      default: begin
        sh = COEF_W - ((slot < LIN_BASE) ? $urandom_range(1, 28) : $urandom_range(1, 40));
        v  = r[47:0] << sh;
        v  = v >>> sh;
      end
    endcase
    return v;
  endfunction

  function automatic warp_beat_t rand_map();
    warp_beat_t b;
    b.action = ACT_MAP;
    b.index  = IDX_W'($urandom);
    b.value  = coef_t'({$urandom, $urandom});
    b.x      = rand_coord();
    b.y      = rand_coord();
    b.z      = rand_coord();
    return b;
  endfunction

  function automatic warp_beat_t rand_load();
    warp_beat_t b;
    b.action = ACT_LOAD;
    b.index  = ($urandom_range(0, 15) == 0) ? IDX_W'($urandom_range(STORE_DEPTH, 31))
                                            : IDX_W'($urandom_range(0, STORE_DEPTH - 1));
    b.value  = rand_coef(b.index);
    b.x      = coord_t'($urandom);
    b.y      = coord_t'($urandom);
    b.z      = coord_t'($urandom);
    return b;
  endfunction

  // Present one beat and hold it until taken
  task automatic send(warp_beat_t b);
    start        <= 1'b1;
    action_i     <= b.action;
    coef_index_i <= b.index;
    coef_value_i <= b.value;
    in_x_i       <= b.x;
    in_y_i       <= b.y;
    in_z_i       <= b.z;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic send_load(int unsigned idx, coef_t val);
    warp_beat_t b;
    b        = rand_load();
    b.index  = IDX_W'(idx);
    b.value  = val;
    send(b);
  endtask

  task automatic send_map(coord_t x, coord_t y, coord_t z);
    warp_beat_t b;
    b   = rand_map();
    b.x = x;
    b.y = y;
    b.z = z;
    send(b);
  endtask

  task automatic pause(int unsigned cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // Hold off until every predicted point has come back, then let the pipe settle
  task automatic drain();
    pause(1);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_dimension(logic [1:0] d);
    drain();
    dimension_we_i <= 1'b1;
    dimension_i    <= d;
    @(posedge clk_i);
    dimension_we_i <= 1'b0;
    pause(2);
  endtask

  // Full coefficient set in one burst; diagonal often kept near one
  task automatic load_warp();
    coef_t v;
    for (int unsigned s = 0; s < STORE_DEPTH; s++) begin
      v = rand_coef(s);
      if (s >= LIN_BASE && s < TRN_BASE && (s - LIN_BASE) % (NUM_LIN + 1) == 0 &&
          $urandom_range(0, 1) == 1)
        v = COEF_ONE + (v >>> 20);
      send_load(s, v);
    end
  endtask

  // Bursts of random length with random gaps; some bursts long
  task automatic run_traffic(int unsigned beats);
    int unsigned sent;
    int unsigned burst;
    sent = 0;
    while (sent < beats) begin
      burst = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 120) : $urandom_range(1, 12);
      repeat (burst) begin
        if ($urandom_range(0, 99) < LOAD_PCT) send(rand_load());
        else send(rand_map());
        sent++;
      end
      pause($urandom_range(1, 9));
    end
  endtask

  initial begin
    logic [1:0] dim_plan[6];
    dim_plan = '{2'd3, 2'd0, DIM_2D, 2'd1, DIM_RESET, DIM_2D};

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Identity warp after reset, coordinate extremes
    send_map('0, '0, '0);
    send_map(32'sh7FFF_FFFF, 32'sh8000_0000, -32'sd1);
    send_map(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sd1);
    // Slots past the store are dropped
    send_load(30, {1'b0, {(COEF_W-1){1'b1}}});
    send_load(31, {1'b1, {(COEF_W-1){1'b0}}});
    send_map(32'sd1, 32'sd2, 32'sd3);
    // Large quadratic and translation terms clip high and low
    send_load(0, {1'b0, {(COEF_W-1){1'b1}}});
    send_map(32'sh7FFF_FFFF, '0, '0);
    send_load(NUM_QUAD, {1'b1, {(COEF_W-1){1'b0}}});
    send_map(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
    send_load(TRN_BASE + 2, {1'b0, {(COEF_W-1){1'b1}}});
    send_map('0, '0, '0);
    send_load(2 * NUM_QUAD + 5, {1'b1, {(COEF_W-1){1'b0}}});

    // 2D: z row is masked, z out is zero and never clips
    write_dimension(DIM_2D);
    send_map(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    send_load(0, '0);
    send_load(NUM_QUAD, '0);
    send_map(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    send_load(TRN_BASE + 1, -COEF_ONE);
    send_map('0, 32'sh8000_0000, '0);
    // Exact half-LSB ties round toward plus infinity
    send_load(TRN_BASE, coef_t'(1) <<< (COEF_FRAC_BITS - COORD_FRAC_BITS - 1));
    send_map('0, '0, '0);
    send_load(TRN_BASE, -(coef_t'(1) <<< (COEF_FRAC_BITS - COORD_FRAC_BITS - 1)));
    send_map('0, '0, '0);

    // Random phases, one per dimension setting
    foreach (dim_plan[i]) begin
      write_dimension(dim_plan[i]);
      load_warp();
      run_traffic(PHASE_BEATS / 2);
      if (i == 0) drain();
      run_traffic(PHASE_BEATS - PHASE_BEATS / 2);
    end

    drain();
    $display("Run covered %0d map beats and %0d coefficient loads over dimension codes 0-3,",
             sb.maps_seen, sb.loads_seen);
    $display("with %0d mapped points clipped; %0d mismatches.", sb.clipped_seen,
             sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
